FILE: rtl/adc_range_calibrate_scale_macros.svh
// Assertion macros for the ADC range calibrate and scale RTL.
`ifndef ADC_RANGE_CALIBRATE_SCALE_MACROS_SVH
`define ADC_RANGE_CALIBRATE_SCALE_MACROS_SVH
`ifndef SYNTHESIS
`define ARCS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ARCS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ARCS_ASSERT(label, prop, msg)
`define ARCS_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

FILE: rtl/arcs_pkg.sv
// Types and constants for the ADC range calibrate and scale block.
`default_nettype none
package arcs_pkg;

  localparam int RANGE_COUNT_DEF = 8;
  localparam int RANGE_W         = 3;
  localparam int HOLD_W          = 16;
  localparam int CNT_W           = 32;
  localparam int WORD_W          = 32;
  localparam int STATUS_W        = 8;
  localparam int COUNT_W         = 24;
  localparam int STEP_W          = 32;
  localparam int OFFS_W          = 32;
  localparam int SCALED_W        = 33;
  localparam int PROD_W          = COUNT_W + STEP_W;
  localparam int FRAC_SHIFT      = 24;
  localparam int OVL_BIT         = 27;
  localparam int ADDR_W          = 3;
  localparam int DATA_W          = 32;

  localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd34;

  // register index taken from paddr[2]
  localparam logic REG_HOLD_OFF = 1'b0;

  localparam logic ACT_CONVERT = 1'b0;
  localparam logic ACT_CAL_WR  = 1'b1;

  localparam logic [RANGE_W-1:0] GAIN_PINS [8] = '{
    3'd0, 3'd1, 3'd4, 3'd2, 3'd5, 3'd3, 3'd6, 3'd7
  };

  // command from the input stage to the range tracker
  typedef struct packed {
    logic                fire;
    logic                action;
    logic [RANGE_W-1:0]  cal_index;
    logic [STEP_W-1:0]   wr_step;
    logic [OFFS_W-1:0]   cal_offs;
    logic [RANGE_W-1:0]  req;
    logic                overload;
  } arcs_cmd_t;

  // per-word fields carried alongside the product
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [RANGE_W-1:0]  gain;
    logic                chan_valid;
    logic [CNT_W-1:0]    ovl_cnt;
    logic [CNT_W-1:0]    chg_cnt;
    logic [OFFS_W-1:0]   offs;
  } arcs_side_t;

endpackage
`default_nettype wire

FILE: rtl/arcs_track.sv
// Range hold-off tracking, calibration tables and event counters.
`default_nettype none
`include "adc_range_calibrate_scale_macros.svh"
module arcs_track #(
  parameter int RANGE_COUNT = arcs_pkg::RANGE_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [arcs_pkg::HOLD_W-1:0]   hold_off,
  input  arcs_pkg::arcs_cmd_t           cmd,
  output logic [arcs_pkg::STEP_W-1:0]   step,
  output logic [arcs_pkg::OFFS_W-1:0]   offs,
  output logic [arcs_pkg::CNT_W-1:0]    ovl_cnt,
  output logic [arcs_pkg::CNT_W-1:0]    chg_cnt
);
  import arcs_pkg::*;

  localparam int IDX_W = (RANGE_COUNT > 1) ? $clog2(RANGE_COUNT) : 1;
  localparam logic [RANGE_W:0] RANGE_LIM = (RANGE_W + 1)'(RANGE_COUNT);
  localparam logic [HOLD_W-1:0] MIS_MAX = '1;

  logic [STEP_W-1:0]  step_tab_r [RANGE_COUNT];
  logic [OFFS_W-1:0]  offs_tab_r [RANGE_COUNT];
  logic [RANGE_W-1:0] applied_r;
  logic [HOLD_W-1:0]  mis_r, mis_nxt;
  logic               pend_r, pend_nxt, pend_mid;
  logic [CNT_W-1:0]   ovl_r, ovl_nxt;
  logic [CNT_W-1:0]   chg_r, chg_nxt;
  logic               conv_c, wr_c, mismatch_c, apply_c;
  logic               applied_ok, wr_ok;

  assign conv_c     = cmd.fire && (cmd.action == ACT_CONVERT);
  assign wr_c       = cmd.fire && (cmd.action == ACT_CAL_WR);
  assign applied_ok = {1'b0, applied_r} < RANGE_LIM;
  assign wr_ok      = {1'b0, cmd.cal_index} < RANGE_LIM;

  // lookup uses the range in force before this word
  assign step = applied_ok ? step_tab_r[applied_r[IDX_W-1:0]] : '0;
  assign offs = applied_ok ? offs_tab_r[applied_r[IDX_W-1:0]] : '0;

  always_comb begin
    mismatch_c = cmd.req != applied_r;
    if (mismatch_c) begin
      mis_nxt = (mis_r == MIS_MAX) ? mis_r : mis_r + 1'b1;
    end else begin
      mis_nxt = '0;
    end
    pend_mid = mismatch_c || pend_r;
    apply_c  = mis_nxt >= hold_off;
    chg_nxt  = (apply_c && pend_mid) ? chg_r + 1'b1 : chg_r;
    pend_nxt = pend_mid && !apply_c;
    ovl_nxt  = cmd.overload ? ovl_r + 1'b1 : ovl_r;
  end

  assign ovl_cnt = ovl_nxt;
  assign chg_cnt = chg_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      applied_r <= '0;
      mis_r     <= '0;
      pend_r    <= 1'b1;
      ovl_r     <= '0;
      chg_r     <= '0;
      for (int i = 0; i < RANGE_COUNT; i++) begin
        step_tab_r[i] <= '0;
        offs_tab_r[i] <= '0;
      end
    end else begin
      if (conv_c) begin
        mis_r  <= mis_nxt;
        pend_r <= pend_nxt;
        ovl_r  <= ovl_nxt;
        chg_r  <= chg_nxt;
        if (apply_c) begin
          applied_r <= cmd.req;
        end
      end
      if (wr_c && wr_ok) begin
        step_tab_r[cmd.cal_index[IDX_W-1:0]] <= cmd.wr_step;
        offs_tab_r[cmd.cal_index[IDX_W-1:0]] <= cmd.cal_offs;
      end
    end
  end

  `ARCS_ASSERT(a_idle_holds, !conv_c |=> $stable(applied_r) && $stable(chg_r) && $stable(mis_r), "range state moved without a convert word")
  `ARCS_ASSERT(a_mis_sat, (mis_r == MIS_MAX) |=> (mis_r == MIS_MAX || mis_r == '0), "mismatch count wrapped")
  `ARCS_ASSERT(a_apply, (conv_c && apply_c) |=> (applied_r == $past(cmd.req)) && !pend_r, "applied range switch not taken")

endmodule
`default_nettype wire

FILE: rtl/arcs_scale.sv
// Multiply stage and result register of the scaling path.
`default_nettype none
module arcs_scale (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           load,
  input  logic [arcs_pkg::COUNT_W-1:0]   count,
  input  logic [arcs_pkg::STEP_W-1:0]    step,
  input  arcs_pkg::arcs_side_t           side,
  output logic                           b_ready,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [arcs_pkg::STATUS_W-1:0]  out_status_byte,
  output logic signed [arcs_pkg::SCALED_W-1:0] out_scaled_value,
  output logic [arcs_pkg::RANGE_W-1:0]   out_gain_select_code,
  output logic                           out_overload_valid,
  output logic [arcs_pkg::CNT_W-1:0]     out_overload_count,
  output logic [arcs_pkg::CNT_W-1:0]     out_range_change_count
);
  import arcs_pkg::*;

  logic                       b_valid_r, out_valid_r, o_ready;
  logic signed [PROD_W:0]     prod_c;
  logic [PROD_W-1:0]          prod_r;
  arcs_side_t                 side_r;
  logic signed [SCALED_W-1:0] val_c;
  logic signed [OFFS_W-1:0]   floor_c;

  assign o_ready = !out_valid_r || out_ready;
  assign b_ready = !b_valid_r || o_ready;

  // signed 24-bit count times unsigned step
  assign prod_c = $signed(count) * $signed({1'b0, step});

  // taking the top bits is the floor of the shift
  assign floor_c = $signed(prod_r[PROD_W-1:FRAC_SHIFT]);
  assign val_c   = {floor_c[OFFS_W-1], floor_c} - {side_r.offs[OFFS_W-1], side_r.offs};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (b_ready) begin
        b_valid_r <= load;
      end
      if (o_ready) begin
        out_valid_r <= b_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && load) begin
      prod_r <= prod_c[PROD_W-1:0];
      side_r <= side;
    end
    if (o_ready && b_valid_r) begin
      out_status_byte        <= side_r.status;
      out_scaled_value       <= val_c;
      out_gain_select_code   <= side_r.gain;
      out_overload_valid     <= side_r.chan_valid;
      out_overload_count     <= side_r.ovl_cnt;
      out_range_change_count <= side_r.chg_cnt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

FILE: rtl/adc_range_calibrate_scale.sv
// Top level of the ADC range calibrate and scale block.
// Takes one word per clock while out_ready holds: a convert word passes through the
// input register, product register and result register and yields one result; a
// calibration write word takes one slot and yields no result. The rate is one word per
// cycle without back-pressure, set by the single 24x32 multiply between the input and
// product registers and by the range tracker, which updates its state once per convert
// word in the same cycle. The hold_off_points register sits at APB byte address 0.
`default_nettype none
module adc_range_calibrate_scale #(
  parameter int RANGE_COUNT = arcs_pkg::RANGE_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [arcs_pkg::ADDR_W-1:0]    paddr,
  input  logic [arcs_pkg::DATA_W-1:0]    pwdata,
  output logic [arcs_pkg::DATA_W-1:0]    prdata,
  output logic                           pready,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_action,
  input  logic [arcs_pkg::RANGE_W-1:0]   in_cal_index,
  input  logic [arcs_pkg::STEP_W-1:0]    in_cal_step_value,
  input  logic signed [arcs_pkg::OFFS_W-1:0] in_cal_offset_value,
  input  logic [arcs_pkg::WORD_W-1:0]    in_sample_word,
  input  logic [arcs_pkg::RANGE_W-1:0]   in_requested_range,
  input  logic                           in_channel_valid,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [arcs_pkg::STATUS_W-1:0]  out_status_byte,
  output logic signed [arcs_pkg::SCALED_W-1:0] out_scaled_value,
  output logic [arcs_pkg::RANGE_W-1:0]   out_gain_select_code,
  output logic                           out_overload_valid,
  output logic [arcs_pkg::CNT_W-1:0]     out_overload_count,
  output logic [arcs_pkg::CNT_W-1:0]     out_range_change_count
);
  import arcs_pkg::*;

  logic [HOLD_W-1:0]  hold_r;
  logic               cfg_wr;
  logic               a_valid_r, a_action_r, a_chan_r;
  logic [RANGE_W-1:0] a_idx_r, a_req_r;
  logic [STEP_W-1:0]  a_step_r;
  logic [OFFS_W-1:0]  a_offs_r;
  logic [WORD_W-1:0]  a_word_r;
  logic               b_ready, a_ready, a_fire, in_fire;
  arcs_cmd_t          cmd;
  arcs_side_t         side;
  logic [STEP_W-1:0]  step;
  logic [OFFS_W-1:0]  offs;
  logic [CNT_W-1:0]   ovl_cnt, chg_cnt;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_HOLD_OFF);
  assign prdata = (paddr[2] == REG_HOLD_OFF) ? {{(DATA_W-HOLD_W){1'b0}}, hold_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= HOLD_RESET;
    end else if (cfg_wr) begin
      hold_r <= pwdata[HOLD_W-1:0];
    end
  end

  // input register
  assign a_ready  = !a_valid_r || b_ready;
  assign in_ready = a_ready;
  assign in_fire  = in_valid && a_ready;
  assign a_fire   = a_valid_r && b_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (a_ready) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_action_r <= in_action;
      a_idx_r    <= in_cal_index;
      a_step_r   <= in_cal_step_value;
      a_offs_r   <= in_cal_offset_value;
      a_word_r   <= in_sample_word;
      a_req_r    <= in_requested_range;
      a_chan_r   <= in_channel_valid;
    end
  end

  always_comb begin
    cmd.fire      = a_fire;
    cmd.action    = a_action_r;
    cmd.cal_index = a_idx_r;
    cmd.wr_step   = a_step_r;
    cmd.cal_offs  = a_offs_r;
    cmd.req       = a_req_r;
    cmd.overload  = a_word_r[OVL_BIT];
  end

  arcs_track #(
    .RANGE_COUNT (RANGE_COUNT)
  ) u_track (
    .clk      (clk),
    .rst_n    (rst_n),
    .hold_off (hold_r),
    .cmd      (cmd),
    .step     (step),
    .offs     (offs),
    .ovl_cnt  (ovl_cnt),
    .chg_cnt  (chg_cnt)
  );

  always_comb begin
    side.status     = a_word_r[WORD_W-1 -: STATUS_W];
    side.gain       = GAIN_PINS[a_req_r];
    side.chan_valid = a_chan_r;
    side.ovl_cnt    = ovl_cnt;
    side.chg_cnt    = chg_cnt;
    side.offs       = offs;
  end

  arcs_scale u_scale (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .load                   (a_valid_r && (a_action_r == ACT_CONVERT)),
    .count                  (a_word_r[COUNT_W-1:0]),
    .step                   (step),
    .side                   (side),
    .b_ready                (b_ready),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_status_byte        (out_status_byte),
    .out_scaled_value       (out_scaled_value),
    .out_gain_select_code   (out_gain_select_code),
    .out_overload_valid     (out_overload_valid),
    .out_overload_count     (out_overload_count),
    .out_range_change_count (out_range_change_count)
  );

endmodule
`default_nettype wire
